// File: rtl/cft_pkg.sv
// shared types and constants for the csv field tokenizer
package cft_pkg;

  localparam int MAX_COL = 256;
  localparam int COL_W   = $clog2(MAX_COL);
  localparam int CNT_W   = COL_W + 1;
  localparam int ROW_W   = 24;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COL - 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [7:0] SEP_RESET = 8'd59;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  typedef enum logic [2:0] {
    Q_UNQUOTED = 3'b001,
    Q_QUOTED   = 3'b010,
    Q_AFTER    = 3'b100
  } quote_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_CHAR      = 2'd1,
    EV_FIELD_END = 2'd2,
    EV_ROW_END   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } op_t;

endpackage

// File: rtl/cft_front.sv
// front end: quote machine that turns each byte into a token op
module cft_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             accept,
  input  logic             cmd,
  input  logic [7:0]       data_byte,
  output cft_pkg::op_t     op
);

  logic [7:0]      separator;
  cft_pkg::quote_t quote_state, quote_state_next;
  logic            line_has_bytes, line_has_bytes_next;
  logic            is_split, sep_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator      <= cft_pkg::SEP_RESET;
      quote_state    <= cft_pkg::Q_UNQUOTED;
      line_has_bytes <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        separator <= cfg_wr_data;
      end
      if (accept) begin
        quote_state    <= quote_state_next;
        line_has_bytes <= line_has_bytes_next;
      end
    end
  end

  assign is_split = (data_byte == cft_pkg::CH_COMMA) || (data_byte == cft_pkg::CH_SEMI)
                 || (data_byte == cft_pkg::CH_TAB);
  assign sep_hit  = is_split && (data_byte == separator);

  always_comb begin
    quote_state_next    = quote_state;
    line_has_bytes_next = line_has_bytes;
    op.kind             = cft_pkg::EV_NONE;
    op.ch               = 8'd0;
    if (cmd == cft_pkg::CMD_EOF) begin
      // end of file only closes a line that holds bytes
      if (line_has_bytes) begin
        op.kind = cft_pkg::EV_ROW_END;
      end
      line_has_bytes_next = 1'b0;
    end else if (data_byte == cft_pkg::CH_NL) begin
      op.kind             = cft_pkg::EV_ROW_END;
      line_has_bytes_next = 1'b0;
    end else begin
      line_has_bytes_next = 1'b1;
      unique case (quote_state)
        cft_pkg::Q_QUOTED: begin
          if (data_byte == cft_pkg::CH_QUOTE) begin
            quote_state_next = cft_pkg::Q_AFTER;
          end else begin
            op.kind = cft_pkg::EV_CHAR;
            op.ch   = data_byte;
          end
        end
        cft_pkg::Q_AFTER: begin
          if (is_split) begin
            // a split byte other than the separator is dropped here
            if (sep_hit) begin
              op.kind          = cft_pkg::EV_FIELD_END;
              quote_state_next = cft_pkg::Q_UNQUOTED;
            end
          end else if (data_byte == cft_pkg::CH_QUOTE) begin
            op.kind          = cft_pkg::EV_CHAR;
            op.ch            = cft_pkg::CH_QUOTE;
            quote_state_next = cft_pkg::Q_QUOTED;
          end else begin
            quote_state_next = cft_pkg::Q_UNQUOTED;
          end
        end
        default: begin
          quote_state_next = cft_pkg::Q_UNQUOTED;
          if (sep_hit) begin
            op.kind = cft_pkg::EV_FIELD_END;
          end else if (data_byte == cft_pkg::CH_QUOTE) begin
            quote_state_next = cft_pkg::Q_QUOTED;
          end else begin
            op.kind = cft_pkg::EV_CHAR;
            op.ch   = data_byte;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/cft_queue.sv
// short op queue between front and back
module cft_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cft_pkg::op_t push_op,
  input  logic         pop,
  output cft_pkg::op_t head_op,
  output logic         empty,
  output logic         full
);

  cft_pkg::op_t                  slots [cft_pkg::QDEPTH];
  logic [cft_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [cft_pkg::QCNT_W-1:0]    fill;

  assign empty   = (fill == '0);
  assign full    = (fill == cft_pkg::QCNT_W'(cft_pkg::QDEPTH));
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cft_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cft_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + cft_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - cft_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/cft_back.sv
// back end: column, row and widest-row counters plus the result register
module cft_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  cft_pkg::op_t               head_op,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_kind,
  output logic [7:0]                 field_char,
  output logic [cft_pkg::COL_W-1:0]  column_index,
  output logic [cft_pkg::ROW_W-1:0]  row_index,
  output logic [cft_pkg::CNT_W-1:0]  field_count,
  output logic [cft_pkg::CNT_W-1:0]  widest_row
);

  logic [cft_pkg::COL_W-1:0] cur_col, cur_col_next;
  logic [cft_pkg::ROW_W-1:0] rows_done, rows_done_next;
  logic [cft_pkg::CNT_W-1:0] max_fields, max_fields_next;
  logic [cft_pkg::CNT_W-1:0] row_count;

  assign pop       = !q_empty && (!out_valid || !out_stall);
  assign row_count = {1'b0, cur_col} + cft_pkg::CNT_W'(1);

  always_comb begin
    cur_col_next    = cur_col;
    rows_done_next  = rows_done;
    max_fields_next = max_fields;
    unique case (head_op.kind)
      cft_pkg::EV_FIELD_END: begin
        if (cur_col != cft_pkg::COL_LAST) begin
          cur_col_next = cur_col + cft_pkg::COL_W'(1);
        end
      end
      cft_pkg::EV_ROW_END: begin
        cur_col_next   = '0;
        rows_done_next = rows_done + cft_pkg::ROW_W'(1);
        if (row_count > max_fields) begin
          max_fields_next = row_count;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur_col    <= '0;
      rows_done  <= '0;
      max_fields <= '0;
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        cur_col    <= cur_col_next;
        rows_done  <= rows_done_next;
        max_fields <= max_fields_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind   <= head_op.kind;
      field_char   <= head_op.ch;
      column_index <= cur_col;
      row_index    <= rows_done;
      field_count  <= (head_op.kind == cft_pkg::EV_ROW_END) ? row_count : '0;
      widest_row   <= max_fields_next;
    end
  end

endmodule

// File: rtl/csv_field_tokenizer.sv
// top level of the csv field tokenizer
// data path: an accepted beat is written into the op queue, then popped into the result register
// throughput: one byte per cycle while out_stall is low; the front quote machine and the back counters each
// keep up with that rate, and a two-entry queue between them absorbs output stalls
// reset (rst, synchronous): quote state unquoted, counters zero, separator back to ';',
// queue and result register empty
module csv_field_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  field_char,
  output logic [7:0]  column_index,
  output logic [23:0] row_index,
  output logic [8:0]  field_count,
  output logic [8:0]  widest_row
);

  cft_pkg::op_t front_op, head_op;
  logic         accept, q_empty, q_full, pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  cft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .op         (front_op)
  );

  cft_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .push_op(front_op),
    .pop    (pop),
    .head_op(head_op),
    .empty  (q_empty),
    .full   (q_full)
  );

  cft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head_op     (head_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .field_char  (field_char),
    .column_index(column_index),
    .row_index   (row_index),
    .field_count (field_count),
    .widest_row  (widest_row)
  );

endmodule

// File: rtl/cft_checker.sv
// port-level checks for the csv field tokenizer, bound to the top level
module cft_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_kind,
  input logic [7:0]  field_char,
  input logic [7:0]  column_index,
  input logic [8:0]  field_count,
  input logic [8:0]  widest_row
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_char_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != cft_pkg::EV_CHAR |-> field_char == 8'd0)
    else $error("field_char set on a non-character beat");

  a_count_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != cft_pkg::EV_ROW_END |-> field_count == 9'd0)
    else $error("field_count set on a non row-end beat");

  // row end reports the column count and widest row covers it
  a_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == cft_pkg::EV_ROW_END |->
      field_count == ({1'b0, column_index} + 9'd1) && widest_row >= field_count)
    else $error("row end count inconsistent");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_kind  (event_kind),
  .field_char  (field_char),
  .column_index(column_index),
  .field_count (field_count),
  .widest_row  (widest_row)
);
